// ===== rtl/lpg_pkg.sv =====
// lpg_pkg: shared types, constants and the microcode program of the line pixel generator
// used by lpg_seq, lpg_datapath and line_pixel_generator_core
`timescale 1ns / 1ps

package lpg_pkg;

	// default coordinate width
	localparam int LPG_COORD_BITS = 6;

	// step counter of the sequencer
	localparam int STEP_BITS = 2;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_FETCH = 2'd0;
	localparam step_t STEP_AXES  = 2'd1;
	localparam step_t STEP_ORDER = 2'd2;
	localparam step_t STEP_WALK  = 2'd3;

	// condition a step waits on before its actions fire
	typedef enum logic [1:0] {
		GATE_NONE = 2'd0,
		GATE_IN   = 2'd1,
		GATE_OUT  = 2'd2
	} gate_t;

	// one control word of the program
	typedef struct packed {
		gate_t gate;
		logic  ld_in;
		logic  swap;
		logic  order;
		logic  emit;
		logic  loop;
		step_t target;
	} ucode_t;

	// datapath strobes, already qualified by the step condition
	typedef struct packed {
		logic ld_in;
		logic swap;
		logic order;
		logic emit;
	} lpg_ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic is_last;
		logic out_free;
	} lpg_stat_t;

	// program rom: fetch endpoints, pick axes, order endpoints, walk the major axis
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		w = '0;
		unique case (step)
			STEP_FETCH: begin
				w.gate  = GATE_IN;
				w.ld_in = 1'b1;
			end
			STEP_AXES: begin
				w.swap = 1'b1;
			end
			STEP_ORDER: begin
				w.order = 1'b1;
			end
			STEP_WALK: begin
				w.gate   = GATE_OUT;
				w.emit   = 1'b1;
				w.loop   = 1'b1;
				w.target = STEP_FETCH;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/lpg_seq.sv =====
// lpg_seq: step counter and control word fetch for the line pixel generator
// depends on lpg_pkg (program rom, control and status structs)
`timescale 1ns / 1ps

module lpg_seq
	import lpg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  lpg_stat_t stat,
	output lpg_ctrl_t ctrl,
	output logic      in_stall
);

	step_t  step_q;
	step_t  step_next;
	ucode_t uw;
	logic   go;

	// current control word
	assign uw = ucode_rom(step_q);

	// step condition
	always_comb begin
		unique case (uw.gate)
			GATE_IN:  go = in_valid;
			GATE_OUT: go = stat.out_free;
			default:  go = 1'b1;
		endcase
	end

	// input side is open only on the fetch step
	assign in_stall = ~uw.ld_in;

	// qualified strobes
	assign ctrl.ld_in = go & uw.ld_in;
	assign ctrl.swap  = go & uw.swap;
	assign ctrl.order = go & uw.order;
	assign ctrl.emit  = go & uw.emit;

	// next step: hold, loop until last, or advance
	always_comb begin
		if (!go) begin
			step_next = step_q;
		end else if (uw.loop) begin
			step_next = stat.is_last ? uw.target : step_q;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// ===== rtl/lpg_datapath.sv =====
// lpg_datapath: endpoint registers, axis swap, remainder walk and output register
// depends on lpg_pkg (control and status structs)
`timescale 1ns / 1ps

module lpg_datapath
	import lpg_pkg::*;
#(
	parameter int COORD_BITS = LPG_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpg_ctrl_t             ctrl,
	output lpg_stat_t             stat,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [31:0]           draw_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [31:0]           pixel_color,
	output logic                  last
);

	localparam int W = COORD_BITS;

	// endpoint registers, rewritten in place as axes are chosen
	logic [W-1:0] p0a_q, p0b_q, p1a_q, p1b_q;
	logic [31:0]  color_q;
	logic         steep_q;

	// walk state
	logic [W-1:0]        major_pos_q, major_end_q, minor_pos_q, major_delta_q;
	logic signed [W:0]   minor_delta_q;
	logic signed [W+1:0] rem_q;

	// output register
	logic         out_valid_q;
	logic [W-1:0] pix_x_q, pix_y_q;
	logic [31:0]  pix_color_q;
	logic         pix_last_q;

	logic [W-1:0]        adx, ady;
	logic                steep_c, flip_c;
	logic [W-1:0]        ma0_c, mi0_c, ma1_c, mi1_c;
	logic signed [W+1:0] rem_sum, dmaj_ext, rem_next;
	logic [W-1:0]        minor_next;

	// axis choice from absolute deltas
	assign adx     = (p0a_q > p1a_q) ? (p0a_q - p1a_q) : (p1a_q - p0a_q);
	assign ady     = (p0b_q > p1b_q) ? (p0b_q - p1b_q) : (p1b_q - p0b_q);
	assign steep_c = adx < ady;

	// endpoint ordering so the major coordinate increases
	assign flip_c = p0a_q > p1a_q;
	assign ma0_c  = flip_c ? p1a_q : p0a_q;
	assign mi0_c  = flip_c ? p1b_q : p0b_q;
	assign ma1_c  = flip_c ? p0a_q : p1a_q;
	assign mi1_c  = flip_c ? p0b_q : p1b_q;

	// remainder step: at most one correction since |dminor| <= dmajor
	assign rem_sum  = rem_q + {minor_delta_q[W], minor_delta_q};
	assign dmaj_ext = {2'b00, major_delta_q};

	always_comb begin
		rem_next   = rem_sum;
		minor_next = minor_pos_q;
		if (!minor_delta_q[W]) begin
			if (rem_sum >= dmaj_ext) begin
				rem_next   = rem_sum - dmaj_ext;
				minor_next = minor_pos_q + {{(W-1){1'b0}}, 1'b1};
			end
		end else begin
			if (rem_sum < $signed({(W+2){1'b0}})) begin
				rem_next   = rem_sum + dmaj_ext;
				minor_next = minor_pos_q - {{(W-1){1'b0}}, 1'b1};
			end
		end
	end

	// status to the sequencer
	assign stat.is_last  = major_pos_q == major_end_q;
	assign stat.out_free = ~out_valid_q | ~out_stall;

	// endpoint load and axis swap
	always_ff @(posedge clk) begin
		if (ctrl.ld_in) begin
			p0a_q   <= start_x;
			p0b_q   <= start_y;
			p1a_q   <= end_x;
			p1b_q   <= end_y;
			color_q <= draw_color;
		end else if (ctrl.swap) begin
			steep_q <= steep_c;
			if (steep_c) begin
				p0a_q <= p0b_q;
				p0b_q <= p0a_q;
				p1a_q <= p1b_q;
				p1b_q <= p1a_q;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (ctrl.order) begin
			major_pos_q   <= ma0_c;
			minor_pos_q   <= mi0_c;
			major_end_q   <= ma1_c;
			major_delta_q <= ma1_c - ma0_c;
			minor_delta_q <= {1'b0, mi1_c} - {1'b0, mi0_c};
			rem_q         <= '0;
		end else if (ctrl.emit && !stat.is_last) begin
			major_pos_q <= major_pos_q + {{(W-1){1'b0}}, 1'b1};
			minor_pos_q <= minor_next;
			rem_q       <= rem_next;
		end
	end

	// output beat payload, axes swapped back
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			pix_x_q     <= steep_q ? minor_pos_q : major_pos_q;
			pix_y_q     <= steep_q ? major_pos_q : minor_pos_q;
			pix_color_q <= color_q;
			pix_last_q  <= stat.is_last;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last        = pix_last_q;

endmodule

// ===== rtl/line_pixel_generator_core.sv =====
// Line pixel generator: takes one segment beat (two endpoints and a color) and emits one
// pixel beat per major-axis step, with last on the final pixel. The axis with the larger
// delta is walked one pixel a cycle unless the output stalls; the minor coordinate follows
// an exact remainder recurrence. A segment passes setup (accept, axis choice, endpoint
// order) and then a walk of |dmajor|+1 pixels. One segment is in work at a time; the
// input is stalled until its last pixel is emitted.
// depends on lpg_pkg, lpg_seq, lpg_datapath
`timescale 1ns / 1ps

module line_pixel_generator_core
	import lpg_pkg::*;
#(
	parameter int COORD_BITS = LPG_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [31:0]           draw_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [31:0]           pixel_color,
	output logic                  last
);

	lpg_ctrl_t ctrl;
	lpg_stat_t stat;

	// control sequencer
	lpg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_stall (in_stall)
	);

	// datapath and output register
	lpg_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.draw_color  (draw_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule

// ===== rtl/lpg_checker.sv =====
// lpg_checker: port-level assertions for line_pixel_generator_core, bound to the top level
// depends on the port list of line_pixel_generator_core
`timescale 1ns / 1ps

module lpg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic last
);

	// a segment beat closes the input through the axis choice and endpoint order setup steps
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a segment beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 in_stall)
		else $error("input open during setup");

	// a pixel that is not the last means the segment is still in work
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open while a segment is mid-walk");

	// a stalled pixel beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("pixel beat dropped while stalled");

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (.*);
